/* design/sht_pkg.sv */
`default_nettype none

package sht_pkg;

	localparam int HEIGHT_W  = 32;
	localparam int TIME_W    = 48;
	localparam int CFG_W     = 32;
	localparam int REC_W     = 16;
	localparam int SCOUNT_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int QUO_W     = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_TOL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY   = 2'd2;

	localparam logic [CFG_W-1:0] HEIGHT_TOL_RST = 32'd6554;
	localparam logic [CFG_W-1:0] MAX_GAP_RST    = 32'd500000;
	localparam logic [REC_W-1:0] RECOVERY_RST   = 16'd5;
	localparam logic [REC_W-1:0] RECOVERY_MIN   = 16'd2;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] sample_height;
		logic                       height_valid;
		logic [TIME_W-1:0]          sample_time;
		logic                       time_valid;
		logic                       has_support;
	} sht_in_t;

	typedef struct packed {
		logic                       recovered;
		logic signed [HEIGHT_W-1:0] mean_height;
		logic                       track_valid;
		logic [SCOUNT_W-1:0]        sample_count;
	} sht_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_DEC,
		ST_FOLD,
		ST_PUSH
	} sht_state_t;

	typedef enum logic [2:0] {
		FP_IDLE,
		FP_MUL,
		FP_SUM,
		FP_ABS,
		FP_RND,
		FP_DIV,
		FP_FIX,
		FP_DONE
	} sht_fold_phase_t;

endpackage

`default_nettype wire

/* design/sht_fold_unit.sv */
`default_nettype none

module sht_fold_unit #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic signed [31:0]     height,
	input  wire logic signed [31:0]     sample,
	input  wire logic [COUNT_BITS-1:0]  count,
	output logic                        done,
	output logic signed [31:0]          mean
);

	localparam int QW       = sht_pkg::QUO_W;
	localparam int SUM_W    = COUNT_BITS + 34;
	localparam int STEP_MAX = (COUNT_BITS > QW) ? COUNT_BITS : QW;
	localparam int STEP_W   = $clog2(STEP_MAX);
	localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(COUNT_BITS - 1);
	localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(QW - 1);

	sht_pkg::sht_fold_phase_t phase_q, phase_n;
	logic [STEP_W-1:0]        step_q;

	logic signed [31:0]       h_q;
	logic signed [31:0]       s_q;
	logic [COUNT_BITS-1:0]    n_q;
	logic [COUNT_BITS:0]      d_q;
	logic [32:0]              hi_q;
	logic [COUNT_BITS-1:0]    lo_q;
	logic [SUM_W-1:0]         sum_q;
	logic                     neg_q;
	logic [COUNT_BITS:0]      rem_q;
	logic [QW-1:0]            dvd_q;
	logic [QW-1:0]            quo_q;
	logic signed [31:0]       mean_q;

	logic [33:0]              mul_add;
	logic [32+COUNT_BITS:0]   prod;
	logic [SUM_W-1:0]         sum_add;
	logic [SUM_W-1:0]         sum_abs;
	logic [SUM_W-1:0]         rnd_add;
	logic [COUNT_BITS+1:0]    r2;
	logic [COUNT_BITS+1:0]    dsub;
	logic                     q_bit;

	assign mul_add = {hi_q[32], hi_q} + (n_q[0] ? {{2{h_q[31]}}, h_q} : 34'd0);
	assign prod    = {hi_q, lo_q};
	assign sum_add = {prod[32+COUNT_BITS], prod} + {{(SUM_W-32){s_q[31]}}, s_q};
	assign sum_abs = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
	assign rnd_add = sum_q + {{(SUM_W-COUNT_BITS){1'b0}}, d_q[COUNT_BITS:1]};
	assign r2      = {rem_q, dvd_q[QW-1]};
	assign dsub    = r2 - {1'b0, d_q};
	assign q_bit   = !dsub[COUNT_BITS+1];

	always_comb begin
		phase_n = phase_q;
		unique case (phase_q)
			sht_pkg::FP_IDLE: phase_n = sht_pkg::FP_IDLE;
			sht_pkg::FP_MUL: begin
				if (step_q == MUL_LAST) begin
					phase_n = sht_pkg::FP_SUM;
				end
			end
			sht_pkg::FP_SUM: phase_n = sht_pkg::FP_ABS;
			sht_pkg::FP_ABS: phase_n = sht_pkg::FP_RND;
			sht_pkg::FP_RND: phase_n = sht_pkg::FP_DIV;
			sht_pkg::FP_DIV: begin
				if (step_q == DIV_LAST) begin
					phase_n = sht_pkg::FP_FIX;
				end
			end
			sht_pkg::FP_FIX: phase_n = sht_pkg::FP_DONE;
			sht_pkg::FP_DONE: phase_n = sht_pkg::FP_DONE;
			default: phase_n = sht_pkg::FP_IDLE;
		endcase
		if (start) begin
			phase_n = sht_pkg::FP_MUL;
		end
	end

	always_comb begin
		done = (phase_q == sht_pkg::FP_DONE);
		mean = mean_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sht_pkg::FP_IDLE;
			step_q  <= '0;
		end else begin
			phase_q <= phase_n;
			if (start) begin
				step_q <= '0;
			end else if (phase_q == sht_pkg::FP_MUL) begin
				step_q <= (step_q == MUL_LAST) ? '0 : step_q + STEP_W'(1);
			end else if (phase_q == sht_pkg::FP_DIV) begin
				step_q <= (step_q == DIV_LAST) ? '0 : step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q  <= height;
			s_q  <= sample;
			n_q  <= count;
			d_q  <= {1'b0, count} + (COUNT_BITS+1)'(1);
			hi_q <= '0;
		end else begin
			unique case (phase_q)
				sht_pkg::FP_MUL: begin
					hi_q <= mul_add[33:1];
					lo_q <= {mul_add[0], lo_q[COUNT_BITS-1:1]};
					n_q  <= n_q >> 1;
				end
				sht_pkg::FP_SUM: begin
					sum_q <= sum_add;
				end
				sht_pkg::FP_ABS: begin
					neg_q <= sum_q[SUM_W-1];
					sum_q <= sum_abs;
				end
				sht_pkg::FP_RND: begin
					rem_q <= rnd_add[QW +: COUNT_BITS+1];
					dvd_q <= rnd_add[QW-1:0];
				end
				sht_pkg::FP_DIV: begin
					rem_q <= q_bit ? dsub[COUNT_BITS:0] : r2[COUNT_BITS:0];
					dvd_q <= dvd_q << 1;
					quo_q <= {quo_q[QW-2:0], q_bit};
				end
				sht_pkg::FP_FIX: begin
					mean_q <= neg_q ? signed'(~quo_q + QW'(1)) : signed'(quo_q);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/stable_height_tracker_unit.sv */
// Surface height tracker with running mean.
//
// Samples enter on the sample channel (valid/ready) and leave as one result on
// the result channel (valid/ready). Configuration is a plain write port:
// cfg_we, cfg_index, cfg_wdata; write it only while no item is in flight.
//
// One item at a time. Every item takes a bit-serial compare pass over the 48
// time bits (gap, gap limit, minimum step, height tolerance). A folded sample
// also waits for the fold unit, started at acceptance: a shift-add multiply,
// then sum, magnitude and rounding, a 32-step restoring divide and a sign
// fix. The next item is taken in the cycle after the result enters the
// output register.
//
// The output register holds a result while result_ready is low; a new item
// can be accepted and worked on meanwhile, and waits before the output until
// the register frees. Reset clears the track and loads the register defaults.
`default_nettype none

module stable_height_tracker_unit #(
	parameter int COUNT_BITS  = 16,
	parameter int MIN_STEP_US = 100
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             sample_valid,
	output logic                                  sample_ready,
	input  wire sht_pkg::sht_in_t                 sample,
	output logic                                  result_valid,
	input  wire logic                             result_ready,
	output sht_pkg::sht_out_t                     result,
	input  wire logic                             cfg_we,
	input  wire logic [sht_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sht_pkg::CFG_W-1:0]        cfg_wdata
);

	localparam int TIME_W = sht_pkg::TIME_W;
	localparam int BIT_W  = $clog2(TIME_W);
	localparam logic [BIT_W-1:0]  BIT_LAST = BIT_W'(TIME_W - 1);
	localparam logic [TIME_W-1:0] MIN_STEP = TIME_W'(MIN_STEP_US);

	sht_pkg::sht_state_t st_q, st_n;

	logic [31:0]                    tol_q;
	logic [31:0]                    max_gap_q;
	logic [sht_pkg::REC_W-1:0]      rec_samp_q;

	logic signed [31:0]             track_height_q;
	logic [TIME_W-1:0]              track_time_q;
	logic                           track_held_q;
	logic [COUNT_BITS-1:0]          track_count_q;

	sht_pkg::sht_in_t               item_q;
	logic [BIT_W-1:0]               bit_q;
	logic [TIME_W-1:0]              t_sh_q;
	logic [TIME_W-1:0]              tt_sh_q;
	logic [TIME_W-1:0]              min_sh_q;
	logic [31:0]                    s_sh_q;
	logic [31:0]                    h_sh_q;
	logic [31:0]                    tol_sh_q;
	logic [31:0]                    gmax_sh_q;
	logic                           bt_q;
	logic                           b1_q;
	logic                           b2_q;
	logic                           gt_max_q;
	logic                           gt_min_q;
	logic                           gt_t1_q;
	logic                           gt_t2_q;
	logic                           rec_en_q;

	sht_pkg::sht_out_t              result_q;
	sht_pkg::sht_out_t              res_n;
	logic                           result_valid_q;

	logic                           accept;
	logic                           push_load;
	logic                           g_bit;
	logic                           d1_bit;
	logic                           d2_bit;
	logic                           clr;
	logic                           restart;
	logic                           fold_go;
	logic                           fold_done;
	logic signed [31:0]             fold_mean;
	logic [COUNT_BITS-1:0]          cnt_inc;
	logic [31:0]                    cnt_ext;

	sht_fold_unit #(
		.COUNT_BITS(COUNT_BITS)
	) u_fold (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.height (track_height_q),
		.sample (sample.sample_height),
		.count  (track_count_q),
		.done   (fold_done),
		.mean   (fold_mean)
	);

	assign accept    = sample_valid && sample_ready;
	assign push_load = (st_q == sht_pkg::ST_PUSH) && (!result_valid_q || result_ready);

	assign g_bit  = t_sh_q[0] ^ tt_sh_q[0] ^ bt_q;
	assign d1_bit = s_sh_q[0] ^ h_sh_q[0] ^ b1_q;
	assign d2_bit = h_sh_q[0] ^ s_sh_q[0] ^ b2_q;

	assign clr = !item_q.height_valid || !item_q.time_valid || !item_q.has_support ||
		(max_gap_q == '0) || (rec_samp_q < sht_pkg::RECOVERY_MIN);
	assign restart = !track_held_q || bt_q || gt_max_q || (gt_t1_q && gt_t2_q);
	assign fold_go = !clr && !restart && gt_min_q;

	assign cnt_inc = (track_count_q == '1) ? track_count_q
		: track_count_q + COUNT_BITS'(1);
	assign cnt_ext = 32'(track_count_q);

	always_comb begin
		res_n.recovered    = rec_en_q && (cnt_ext >= 32'(rec_samp_q));
		res_n.mean_height  = track_height_q;
		res_n.track_valid  = track_held_q;
		res_n.sample_count = (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : cnt_ext[15:0];
	end

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			sht_pkg::ST_IDLE: begin
				if (accept) begin
					st_n = sht_pkg::ST_CMP;
				end
			end
			sht_pkg::ST_CMP: begin
				if (bit_q == BIT_LAST) begin
					st_n = sht_pkg::ST_DEC;
				end
			end
			sht_pkg::ST_DEC: st_n = fold_go ? sht_pkg::ST_FOLD : sht_pkg::ST_PUSH;
			sht_pkg::ST_FOLD: begin
				if (fold_done) begin
					st_n = sht_pkg::ST_PUSH;
				end
			end
			sht_pkg::ST_PUSH: begin
				if (push_load) begin
					st_n = sht_pkg::ST_IDLE;
				end
			end
			default: st_n = sht_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		sample_ready = (st_q == sht_pkg::ST_IDLE);
		result_valid = result_valid_q;
		result       = result_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= sht_pkg::ST_IDLE;
			bit_q          <= '0;
			tol_q          <= sht_pkg::HEIGHT_TOL_RST;
			max_gap_q      <= sht_pkg::MAX_GAP_RST;
			rec_samp_q     <= sht_pkg::RECOVERY_RST;
			track_height_q <= '0;
			track_time_q   <= '0;
			track_held_q   <= 1'b0;
			track_count_q  <= '0;
			rec_en_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			st_q <= st_n;

			if (accept) begin
				bit_q <= '0;
			end else if (st_q == sht_pkg::ST_CMP) begin
				bit_q <= bit_q + BIT_W'(1);
			end

			if (cfg_we) begin
				unique case (cfg_index)
					sht_pkg::CFG_HEIGHT_TOL: tol_q      <= cfg_wdata;
					sht_pkg::CFG_MAX_GAP:    max_gap_q  <= cfg_wdata;
					sht_pkg::CFG_RECOVERY:   rec_samp_q <= cfg_wdata[sht_pkg::REC_W-1:0];
					default: begin
					end
				endcase
			end

			if (st_q == sht_pkg::ST_DEC) begin
				rec_en_q <= !clr && !restart;
				priority if (clr) begin
					track_height_q <= '0;
					track_time_q   <= '0;
					track_held_q   <= 1'b0;
					track_count_q  <= '0;
				end else if (restart) begin
					track_height_q <= item_q.sample_height;
					track_time_q   <= item_q.sample_time;
					track_held_q   <= 1'b1;
					track_count_q  <= COUNT_BITS'(1);
				end else begin
				end
			end else if ((st_q == sht_pkg::ST_FOLD) && fold_done) begin
				track_height_q <= fold_mean;
				track_time_q   <= item_q.sample_time;
				track_held_q   <= 1'b1;
				track_count_q  <= cnt_inc;
			end

			if (push_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q    <= sample;
			t_sh_q    <= sample.sample_time;
			tt_sh_q   <= track_time_q;
			min_sh_q  <= MIN_STEP;
			s_sh_q    <= sample.sample_height;
			h_sh_q    <= track_height_q;
			tol_sh_q  <= tol_q;
			gmax_sh_q <= max_gap_q;
			bt_q      <= 1'b0;
			b1_q      <= 1'b0;
			b2_q      <= 1'b0;
			gt_max_q  <= 1'b0;
			gt_min_q  <= 1'b0;
			gt_t1_q   <= 1'b0;
			gt_t2_q   <= 1'b0;
		end else if (st_q == sht_pkg::ST_CMP) begin
			t_sh_q    <= t_sh_q >> 1;
			tt_sh_q   <= tt_sh_q >> 1;
			min_sh_q  <= min_sh_q >> 1;
			s_sh_q    <= {s_sh_q[31], s_sh_q[31:1]};
			h_sh_q    <= {h_sh_q[31], h_sh_q[31:1]};
			tol_sh_q  <= tol_sh_q >> 1;
			gmax_sh_q <= gmax_sh_q >> 1;
			bt_q <= (!t_sh_q[0] && tt_sh_q[0]) || (!(t_sh_q[0] ^ tt_sh_q[0]) && bt_q);
			b1_q <= (!s_sh_q[0] && h_sh_q[0]) || (!(s_sh_q[0] ^ h_sh_q[0]) && b1_q);
			b2_q <= (!h_sh_q[0] && s_sh_q[0]) || (!(h_sh_q[0] ^ s_sh_q[0]) && b2_q);
			if (g_bit != gmax_sh_q[0]) begin
				gt_max_q <= g_bit;
			end
			if (g_bit != min_sh_q[0]) begin
				gt_min_q <= g_bit;
			end
			if (d1_bit != tol_sh_q[0]) begin
				gt_t1_q <= d1_bit;
			end
			if (d2_bit != tol_sh_q[0]) begin
				gt_t2_q <= d2_bit;
			end
		end

		if (push_load) begin
			result_q <= res_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		track_held_q == (track_count_q != '0))
		else $error("track held flag disagrees with sample count");

	a_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(st_q == sht_pkg::ST_PUSH))
		else $error("result raised outside the push state");

	a_time_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(track_time_q) |->
			$past(st_q == sht_pkg::ST_DEC || st_q == sht_pkg::ST_FOLD))
		else $error("track time changed outside decide or fold");
`endif

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;

	localparam int                            CYCLE_LIMIT  = 500000;
	localparam int                            DRAIN_CYCLES = 120;
	localparam int                            MAX_REPORTS  = 10;
	localparam int                            MIN_STEP_US  = 100;
	localparam int                            NUM_PHASES   = 6;
	localparam logic [sht_pkg::SCOUNT_W-1:0]  COUNT_SAT    = '1;
	localparam logic [sht_pkg::CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          sample_valid = 1'b0;
	logic                          sample_ready;
	sht_pkg::sht_in_t              sample       = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	sht_pkg::sht_out_t             result;
	logic                          cfg_we       = 1'b0;
	logic [sht_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
	logic [sht_pkg::CFG_W-1:0]     cfg_wdata    = '0;

	logic signed [sht_pkg::HEIGHT_W-1:0] trk_height;
	logic [sht_pkg::TIME_W-1:0]          trk_time;
	logic                                trk_held;
	logic [sht_pkg::SCOUNT_W-1:0]        trk_count;
	logic [sht_pkg::CFG_W-1:0]           tol_cfg;
	logic [sht_pkg::CFG_W-1:0]           gap_cfg;
	logic [sht_pkg::REC_W-1:0]           rec_cfg;

	sht_pkg::sht_out_t pending_results[$];
	int       errors       = 0;
	int       cycle_count  = 0;
	int       burst_left   = 0;
	int       rx_hold      = 0;
	int       n_samples    = 0;
	int       n_folds      = 0;
	int       n_recoveries = 0;
	int       n_settings   = 0;

	stable_height_tracker_unit #(
		.COUNT_BITS (sht_pkg::SCOUNT_W),
		.MIN_STEP_US(MIN_STEP_US)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void clear_track();
		trk_height = '0;
		trk_time   = '0;
		trk_held   = 1'b0;
		trk_count  = '0;
	endfunction

	function automatic sht_pkg::sht_in_t mk_sample(
			input logic signed [sht_pkg::HEIGHT_W-1:0] h, input logic hv,
			input logic [sht_pkg::TIME_W-1:0] t, input logic tv, input logic sup);
		sht_pkg::sht_in_t s;
		s.sample_height = h;
		s.height_valid  = hv;
		s.sample_time   = t;
		s.time_valid    = tv;
		s.has_support   = sup;
		return s;
	endfunction

	function automatic sht_pkg::sht_out_t track_sample(input sht_pkg::sht_in_t s);
		sht_pkg::sht_out_t          r;
		logic [sht_pkg::TIME_W-1:0] step;
		longint                     diff;
		longint                     sum;
		longint unsigned            adiff;
		longint unsigned            mag;
		longint unsigned            den;
		longint unsigned            quo;
		logic                       cont;
		logic                       same;
		logic                       rec;
		rec = 1'b0;
		if (!s.height_valid || !s.time_valid || !s.has_support || gap_cfg == '0 ||
				rec_cfg < sht_pkg::RECOVERY_MIN) begin
			clear_track();
		end else begin
			step  = s.sample_time - trk_time;
			cont  = trk_held && s.sample_time >= trk_time &&
				step <= sht_pkg::TIME_W'(gap_cfg);
			diff  = longint'($signed(s.sample_height)) - longint'(trk_height);
			adiff = (diff < 0) ? -diff : diff;
			same  = trk_held && adiff <= tol_cfg;
			if (!cont || !same) begin
				trk_height = s.sample_height;
				trk_time   = s.sample_time;
				trk_count  = sht_pkg::SCOUNT_W'(1);
				trk_held   = 1'b1;
			end else begin
				if (step > MIN_STEP_US) begin
					sum = longint'(trk_height) * longint'({1'b0, trk_count}) +
						longint'($signed(s.sample_height));
					den = longint'({1'b0, trk_count}) + 1;
					mag = (sum < 0) ? -sum : sum;
					quo = (mag + den / 2) / den;
					trk_height = (sum < 0) ? -quo[sht_pkg::HEIGHT_W-1:0] :
						quo[sht_pkg::HEIGHT_W-1:0];
					trk_time   = s.sample_time;
					if (trk_count != COUNT_SAT)
						trk_count++;
					n_folds++;
				end
				rec = trk_count >= rec_cfg;
			end
		end
		if (rec)
			n_recoveries++;
		r.recovered    = rec;
		r.mean_height  = trk_height;
		r.track_valid  = trk_held;
		r.sample_count = trk_count;
		return r;
	endfunction

	task automatic send_sample(input sht_pkg::sht_in_t s);
		int idle;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (idle > 0) begin
				sample_valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
		burst_left--;
		sample_valid <= 1'b1;
		sample       <= s;
		pending_results = {pending_results, track_sample(s)};
		n_samples++;
		do @(posedge clk); while (!sample_ready);
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [sht_pkg::CFG_IDX_W-1:0] idx,
			input logic [sht_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sht_pkg::CFG_HEIGHT_TOL: tol_cfg = data;
			sht_pkg::CFG_MAX_GAP:    gap_cfg = data;
			sht_pkg::CFG_RECOVERY:   rec_cfg = data[sht_pkg::REC_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [sht_pkg::CFG_W-1:0] tol,
			input logic [sht_pkg::CFG_W-1:0] max_gap, input logic [sht_pkg::REC_W-1:0] rec);
		wait_drained();
		write_cfg(sht_pkg::CFG_HEIGHT_TOL, tol);
		write_cfg(sht_pkg::CFG_MAX_GAP, max_gap);
		// upper bits of the recovery write are don't-care
		write_cfg(sht_pkg::CFG_RECOVERY, {16'($urandom()), rec});
		n_settings++;
	endtask

	function automatic sht_pkg::sht_in_t random_sample();
		sht_pkg::sht_in_t           s;
		logic [sht_pkg::TIME_W-1:0] dt;
		longint                     delta;
		int unsigned                hi;
		int                         kind;
		kind = $urandom_range(0, 99);
		s = mk_sample(trk_height, 1'b1, trk_time, 1'b1, 1'b1);
		if (!trk_held) begin
			case ($urandom_range(0, 3))
				0:       s.sample_time = sht_pkg::TIME_W'({$urandom(), $urandom()});
				1:       s.sample_time = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 4000);
				default: s.sample_time = sht_pkg::TIME_W'($urandom());
			endcase
			case ($urandom_range(0, 3))
				0:       s.sample_height = $urandom();
				1:       s.sample_height = 32'sh7FFF_FFFF - $urandom_range(0, 1000);
				2:       s.sample_height = 32'sh8000_0000 + $urandom_range(0, 1000);
				default: s.sample_height = $urandom_range(0, 32'h00FF_FFFF) - 32'sh0080_0000;
			endcase
		end
		if (kind < 80) begin
			hi = (gap_cfg < 5000) ? gap_cfg : 5000;
			case ($urandom_range(0, 9))
				0, 1:    dt = sht_pkg::TIME_W'($urandom_range(0, MIN_STEP_US));
				2:       dt = sht_pkg::TIME_W'(gap_cfg);
				default: dt = (hi > MIN_STEP_US) ?
					sht_pkg::TIME_W'($urandom_range(MIN_STEP_US + 1, hi)) :
					sht_pkg::TIME_W'($urandom_range(0, hi));
			endcase
			if (trk_held)
				s.sample_time = trk_time + dt;
			if (kind < 70) begin
				hi = (tol_cfg < 32'h0010_0000) ? tol_cfg : 32'h0010_0000;
				delta = ($urandom_range(0, 7) == 0) ? longint'(tol_cfg) :
					longint'($urandom_range(0, hi));
			end else if ($urandom_range(0, 1) == 0) begin
				delta = longint'(tol_cfg) + 1 + longint'($urandom_range(0, 1000));
			end else begin
				delta = longint'($signed(32'($urandom())));
			end
			if ($urandom_range(0, 1) == 0)
				delta = -delta;
			if (trk_held)
				s.sample_height = 32'(longint'(trk_height) + delta);
		end else if (kind < 86) begin
			if ($urandom_range(0, 1) == 0)
				s.sample_time = trk_time - sht_pkg::TIME_W'($urandom_range(1, 1000));
			else
				s.sample_time = trk_time + sht_pkg::TIME_W'(gap_cfg) +
					sht_pkg::TIME_W'($urandom_range(1, 1000));
		end else if (kind < 92) begin
			{s.height_valid, s.time_valid, s.has_support} = 3'($urandom_range(0, 6));
		end else begin
			s.sample_height = $urandom();
			s.sample_time   = sht_pkg::TIME_W'({$urandom(), $urandom()});
			{s.height_valid, s.time_valid, s.has_support} = 3'($urandom_range(0, 7));
		end
		return s;
	endfunction

	task automatic test_flag_clearing();
		send_sample(mk_sample(32'sh0001_0000, 1'b1, 48'd1000, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh0001_0800, 1'b1, 48'd1200, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh0001_0000, 1'b0, 48'd1400, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh0001_0000, 1'b1, 48'd1600, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh0001_0000, 1'b1, 48'd1800, 1'b0, 1'b1));
		send_sample(mk_sample(32'sh0001_0000, 1'b1, 48'd2000, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh0001_0000, 1'b1, 48'd2200, 1'b1, 1'b0));
	endtask

	task automatic test_track_rules();
		send_sample(mk_sample(32'sh7FFF_FFFF, 1'b1, 48'd0, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh7FFF_FFFF, 1'b1, 48'd100, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh7FFF_E665, 1'b1, 48'd101, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh7FFF_FFFF, 1'b1, 48'd50, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh7FFF_FFFF, 1'b1, 48'd500051, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh7FFF_FFFF, 1'b1, 48'd1000051, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh7FFF_F000, 1'b1, 48'd1000152, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh7FFF_FFFF, 1'b1, 48'd1001152, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh7FFF_FFFF, 1'b1, 48'd1002152, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh7FFF_C000, 1'b1, 48'd1003152, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh8000_0000, 1'b1, 48'hFFFF_FFFF_FF00, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh8000_0001, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh8000_0001, 1'b1, 48'd5, 1'b1, 1'b1));
	endtask

	task automatic test_config_extremes();
		apply_settings(sht_pkg::HEIGHT_TOL_RST, '0, sht_pkg::RECOVERY_RST);
		send_sample(mk_sample(32'sh0000_0000, 1'b1, 48'd10, 1'b1, 1'b1));
		apply_settings('0, '1, 16'd0);
		send_sample(mk_sample(32'sh0000_0000, 1'b1, 48'd20, 1'b1, 1'b1));
		apply_settings('0, '1, 16'd1);
		send_sample(mk_sample(32'sh0000_0000, 1'b1, 48'd30, 1'b1, 1'b1));
		apply_settings('0, '1, sht_pkg::RECOVERY_MIN);
		send_sample(mk_sample(32'sh0000_0000, 1'b1, 48'd0, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh0000_0000, 1'b1, 48'hFFFF_FFFF, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh0000_0001, 1'b1, 48'h1_0000_00C7, 1'b1, 1'b1));
		apply_settings('1, '1, sht_pkg::RECOVERY_MIN);
		send_sample(mk_sample(32'sh7FFF_FFFF, 1'b1, 48'd0, 1'b1, 1'b1));
		send_sample(mk_sample(32'sh8000_0000, 1'b1, 48'd200, 1'b1, 1'b1));
		wait_drained();
		write_cfg(CFG_UNUSED, $urandom());
		send_sample(mk_sample(32'sh8000_0000, 1'b1, 48'd400, 1'b1, 1'b1));
	endtask

	task automatic test_random_tracks();
		logic [sht_pkg::CFG_W-1:0] tol;
		logic [sht_pkg::CFG_W-1:0] max_gap;
		logic [sht_pkg::REC_W-1:0] rec;
		int                        items;
		for (int p = 0; p < NUM_PHASES; p++) begin
			case ($urandom_range(0, 3))
				0:       tol = $urandom_range(0, 64);
				1:       tol = $urandom_range(0, 32'h0002_0000);
				2:       tol = $urandom();
				default: tol = '1;
			endcase
			case ($urandom_range(0, 15))
				0:             max_gap = '0;
				1, 2, 3, 4, 5: max_gap = $urandom_range(1, 2000);
				6, 7, 8, 9:    max_gap = $urandom_range(2000, 600000);
				10, 11, 12:    max_gap = $urandom();
				default:       max_gap = '1;
			endcase
			case ($urandom_range(0, 15))
				0:          rec = sht_pkg::REC_W'($urandom_range(0, 1));
				12, 13, 14: rec = sht_pkg::REC_W'($urandom_range(9, 65535));
				15:         rec = '1;
				default:    rec = sht_pkg::REC_W'($urandom_range(2, 8));
			endcase
			if (p == NUM_PHASES - 1) begin
				tol     = '1;
				max_gap = '1;
				rec     = sht_pkg::RECOVERY_MIN;
			end
			apply_settings(tol, max_gap, rec);
			items = (max_gap == '0 || rec < sht_pkg::RECOVERY_MIN) ? 10 : 70;
			for (int i = 0; i < items; i++) begin
				if ($urandom_range(0, 49) == 0)
					wait_drained();
				send_sample(random_sample());
			end
		end
	endtask

	always @(posedge clk) begin
		if (rx_hold == 0) begin
			result_ready <= ($urandom_range(0, 2) != 0);
			rx_hold      <= $urandom_range(1, 30);
		end else begin
			rx_hold <= rx_hold - 1;
		end
	end

	always @(posedge clk) begin : check_result
		sht_pkg::sht_out_t want;
		logic              bad;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result %p", result);
			end else begin
				want = pending_results.pop_front();
				bad = result.recovered !== want.recovered ||
					result.mean_height !== want.mean_height ||
					result.track_valid !== want.track_valid ||
					result.sample_count !== want.sample_count;
				if (bad) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("mismatch: expected rec=%0b mean=%0d held=%0b count=%0d",
							want.recovered, want.mean_height, want.track_valid,
							want.sample_count);
						$display("          got      rec=%0b mean=%0d held=%0b count=%0d",
							result.recovered, result.mean_height, result.track_valid,
							result.sample_count);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("[stable_height_tracker_unit] ERROR");
			$finish;
		end
	end

	initial begin
		clear_track();
		tol_cfg = sht_pkg::HEIGHT_TOL_RST;
		gap_cfg = sht_pkg::MAX_GAP_RST;
		rec_cfg = sht_pkg::RECOVERY_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_flag_clearing();
		test_track_rules();
		test_config_extremes();
		test_random_tracks();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d samples under %0d register settings: %0d folded into the mean, %0d recovered",
			n_samples, n_settings, n_folds, n_recoveries);
		$display("%0d mismatches in %0d cycles", errors, cycle_count);
		if (errors == 0 && pending_results.size() == 0)
			$display("[stable_height_tracker_unit] OK");
		else
			$display("[stable_height_tracker_unit] ERROR");
		$finish;
	end

endmodule

/* files.f */
design/sht_pkg.sv
design/sht_fold_unit.sv
design/stable_height_tracker_unit.sv
test/testbench.sv
